>>> sv/urb_pkg.sv
// urb_pkg: shared types and constants of the ultrasonic range bar controller
// no dependencies; used by every module of the block
`default_nettype none

package urb_pkg;

    localparam int ECHO_COUNT_BITS  = 16;
    localparam int PAUSE_COUNT_BITS = 20;
    localparam int SCALE_BITS       = 16;
    localparam int FRAC_BITS        = 16;
    localparam int PROD_BITS        = ECHO_COUNT_BITS + SCALE_BITS;
    localparam int DIST_BITS        = 8;
    localparam int BAR_BITS         = 4;
    localparam int APB_ADDR_BITS    = 5;
    localparam int APB_DATA_BITS    = 32;
    localparam int IN_TDATA_BITS    = 8;
    localparam int OUT_TDATA_BITS   = 16;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [2:0] REG_PAUSE_TICKS   = 3'd1;
    localparam logic [2:0] REG_SCALE_Q16     = 3'd2;
    localparam logic [2:0] REG_LEVEL_ONE     = 3'd3;
    localparam logic [2:0] REG_LEVEL_TWO     = 3'd4;
    localparam logic [2:0] REG_LEVEL_THREE   = 3'd5;
    localparam logic [2:0] REG_LEVEL_FOUR    = 3'd6;

    // thermometer bar codes
    localparam logic [BAR_BITS-1:0] BAR_OFF   = 4'b0000;
    localparam logic [BAR_BITS-1:0] BAR_ONE   = 4'b0001;
    localparam logic [BAR_BITS-1:0] BAR_TWO   = 4'b0011;
    localparam logic [BAR_BITS-1:0] BAR_THREE = 4'b0111;
    localparam logic [BAR_BITS-1:0] BAR_FOUR  = 4'b1111;

    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_WAIT    = 2'd1,
        PH_COUNT   = 2'd2,
        PH_PAUSE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [9:0]            trigger_ticks;
        logic [19:0]           pause_ticks;
        logic [SCALE_BITS-1:0] scale_q16;
        logic [DIST_BITS-1:0]  level_one_cm;
        logic [DIST_BITS-1:0]  level_two_cm;
        logic [DIST_BITS-1:0]  level_three_cm;
        logic [DIST_BITS-1:0]  level_four_cm;
    } cfg_t;

    // transaction held between the phase stage and the output stage
    typedef struct packed {
        logic                 trig;
        logic                 meas;
        logic [PROD_BITS-1:0] prod;
    } stage_t;

endpackage

`default_nettype wire

>>> sv/urb_cfg_regs.sv
// urb_cfg_regs: apb register file holding the ranging and bar settings
// depends on urb_pkg
`default_nettype none

module urb_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [urb_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [urb_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [urb_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                    pready,
    output urb_pkg::cfg_t                           cfg
);
    import urb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_TRIGGER_TICKS: cfg_next.trigger_ticks  = pwdata[9:0];
                REG_PAUSE_TICKS:   cfg_next.pause_ticks    = pwdata[19:0];
                REG_SCALE_Q16:     cfg_next.scale_q16      = pwdata[SCALE_BITS-1:0];
                REG_LEVEL_ONE:     cfg_next.level_one_cm   = pwdata[DIST_BITS-1:0];
                REG_LEVEL_TWO:     cfg_next.level_two_cm   = pwdata[DIST_BITS-1:0];
                REG_LEVEL_THREE:   cfg_next.level_three_cm = pwdata[DIST_BITS-1:0];
                REG_LEVEL_FOUR:    cfg_next.level_four_cm  = pwdata[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRIGGER_TICKS: prdata = APB_DATA_BITS'(cfg_reg.trigger_ticks);
            REG_PAUSE_TICKS:   prdata = APB_DATA_BITS'(cfg_reg.pause_ticks);
            REG_SCALE_Q16:     prdata = APB_DATA_BITS'(cfg_reg.scale_q16);
            REG_LEVEL_ONE:     prdata = APB_DATA_BITS'(cfg_reg.level_one_cm);
            REG_LEVEL_TWO:     prdata = APB_DATA_BITS'(cfg_reg.level_two_cm);
            REG_LEVEL_THREE:   prdata = APB_DATA_BITS'(cfg_reg.level_three_cm);
            REG_LEVEL_FOUR:    prdata = APB_DATA_BITS'(cfg_reg.level_four_cm);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks  <= 10'd10;
            cfg_reg.pause_ticks    <= 20'd100000;
            cfg_reg.scale_q16      <= 16'd1114;
            cfg_reg.level_one_cm   <= 8'd5;
            cfg_reg.level_two_cm   <= 8'd10;
            cfg_reg.level_three_cm <= 8'd15;
            cfg_reg.level_four_cm  <= 8'd20;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/urb_phase_fsm.sv
// urb_phase_fsm: trigger / wait / count / pause sequencer, one tick per transaction,
// registers the echo product for the output stage; depends on urb_pkg
`default_nettype none

module urb_phase_fsm (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  urb_pkg::cfg_t      cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          echo,
    input  wire logic          out_take,
    output logic               st_valid,
    output urb_pkg::stage_t    st
);
    import urb_pkg::*;

    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic [PAUSE_COUNT_BITS-1:0] phase_count_reg;
    logic [PAUSE_COUNT_BITS-1:0] phase_count_next;
    logic [PAUSE_COUNT_BITS-1:0] trig_inc;
    logic [ECHO_COUNT_BITS-1:0]  echo_count_reg;
    logic [ECHO_COUNT_BITS-1:0]  echo_count_next;
    logic [PAUSE_COUNT_BITS-1:0] trig_cmp;
    logic [PAUSE_COUNT_BITS-1:0] pause_cmp;
    logic [PROD_BITS-1:0]        prod;
    logic                        st_valid_reg;
    logic                        st_valid_next;
    stage_t                      st_reg;
    stage_t                      st_next;
    logic                        acc;

    assign in_ready = !st_valid_reg || out_take;
    assign acc      = in_valid && in_ready;

    // thresholds as the phase counter sees them
    assign trig_cmp  = PAUSE_COUNT_BITS'(cfg.trigger_ticks);
    assign pause_cmp = PAUSE_COUNT_BITS'(cfg.pause_ticks);
    assign prod      = echo_count_reg * cfg.scale_q16;

    always_comb begin
        phase_next       = phase_reg;
        phase_count_next = phase_count_reg;
        echo_count_next  = echo_count_reg;
        trig_inc         = '0;
        st_next          = st_reg;
        st_next.trig     = 1'b0;
        st_next.meas     = 1'b0;
        st_next.prod     = prod;

        // pause end falls straight through into the first trigger tick
        if (phase_next == PH_PAUSE) begin
            if (phase_count_next >= pause_cmp) begin
                phase_next       = PH_TRIGGER;
                phase_count_next = '0;
                echo_count_next  = '0;
            end else begin
                phase_count_next = phase_count_next + 1'b1;
            end
        end

        case (phase_next)
            PH_TRIGGER: begin
                st_next.trig = 1'b1;
                trig_inc     = phase_count_next + 1'b1;
                if (trig_inc >= trig_cmp) begin
                    phase_next       = PH_WAIT;
                    phase_count_next = '0;
                    echo_count_next  = '0;
                end else begin
                    phase_count_next = trig_inc;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    echo_count_next = ECHO_COUNT_BITS'(1);
                    phase_next      = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (echo) begin
                    echo_count_next = echo_count_reg + 1'b1;
                end else begin
                    st_next.meas     = 1'b1;
                    phase_next       = PH_PAUSE;
                    phase_count_next = '0;
                end
            end
            default: ;
        endcase

        if (acc) begin
            st_valid_next = 1'b1;
        end else if (out_take) begin
            st_valid_next = 1'b0;
        end else begin
            st_valid_next = st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_TRIGGER;
            phase_count_reg <= '0;
            echo_count_reg  <= '0;
            st_valid_reg    <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            if (acc) begin
                phase_reg       <= phase_next;
                phase_count_reg <= phase_count_next;
                echo_count_reg  <= echo_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            st_reg <= st_next;
        end
    end

    assign st_valid = st_valid_reg;
    assign st       = st_reg;

    // echo fall in the count phase starts a measurement and the pause
    a_meas_on_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && phase_reg == PH_COUNT && !echo) |=>
            (phase_reg == PH_PAUSE && st_valid_reg && st_reg.meas))
        else $error("echo fall did not start a measurement");

    // no trigger while waiting for or timing the echo
    a_no_trig_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && (phase_reg == PH_WAIT || phase_reg == PH_COUNT)) |=> !st_reg.trig)
        else $error("trigger driven during echo phases");

    // sequencer state moves only on an accepted tick
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !acc |=> ($stable(phase_reg) && $stable(phase_count_reg) && $stable(echo_count_reg)))
        else $error("sequencer state changed without a transaction");

    // a measurement only ever comes out of the count phase
    a_meas_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && phase_reg != PH_COUNT) |=> !st_reg.meas)
        else $error("measurement outside the count phase");

endmodule

`default_nettype wire

>>> sv/urb_bar_out.sv
// urb_bar_out: distance saturation, bar thresholds and the output register
// depends on urb_pkg
`default_nettype none

module urb_bar_out (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  urb_pkg::cfg_t                          cfg,
    input  wire logic                              st_valid,
    input  urb_pkg::stage_t                        st,
    output logic                                   out_take,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic                                   m_trigger,
    output logic      [urb_pkg::BAR_BITS-1:0]      m_bar,
    output logic      [urb_pkg::DIST_BITS-1:0]     m_distance,
    output logic                                   m_dist_valid
);
    import urb_pkg::*;

    logic [ECHO_COUNT_BITS-1:0] dist_full;
    logic [DIST_BITS-1:0]       dist_sat;
    logic [BAR_BITS-1:0]        bar_new;
    logic                       load;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic                       m_trig_reg;
    logic                       m_dvalid_reg;
    logic [BAR_BITS-1:0]        bar_latch_reg;
    logic [BAR_BITS-1:0]        bar_latch_next;
    logic [DIST_BITS-1:0]       dist_latch_reg;
    logic [DIST_BITS-1:0]       dist_latch_next;

    assign out_take = !m_valid_reg || m_tready;
    assign load     = st_valid && out_take;

    // drop the q16 fraction, clip to 8 bits
    assign dist_full = st.prod[PROD_BITS-1:FRAC_BITS];
    assign dist_sat  = (dist_full > ECHO_COUNT_BITS'(255)) ? DIST_BITS'(255)
                                                          : dist_full[DIST_BITS-1:0];

    always_comb begin
        if (dist_sat <= cfg.level_one_cm) begin
            bar_new = BAR_ONE;
        end else if (dist_sat <= cfg.level_two_cm) begin
            bar_new = BAR_TWO;
        end else if (dist_sat <= cfg.level_three_cm) begin
            bar_new = BAR_THREE;
        end else if (dist_sat <= cfg.level_four_cm) begin
            bar_new = BAR_FOUR;
        end else begin
            bar_new = BAR_OFF;
        end
    end

    always_comb begin
        bar_latch_next  = bar_latch_reg;
        dist_latch_next = dist_latch_reg;
        if (load && st.meas) begin
            bar_latch_next  = bar_new;
            dist_latch_next = dist_sat;
        end
        m_valid_next = out_take ? st_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            bar_latch_reg  <= BAR_OFF;
            dist_latch_reg <= '0;
        end else begin
            m_valid_reg    <= m_valid_next;
            bar_latch_reg  <= bar_latch_next;
            dist_latch_reg <= dist_latch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_trig_reg   <= st.trig;
            m_dvalid_reg <= st.meas;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_trigger    = m_trig_reg;
    assign m_bar        = bar_latch_reg;
    assign m_distance   = dist_latch_reg;
    assign m_dist_valid = m_dvalid_reg;

endmodule

`default_nettype wire

>>> sv/ultrasonic_range_bar_controller.sv
// ultrasonic_range_bar_controller: top level of the echo ranging and led bar block
// depends on urb_pkg, urb_cfg_regs, urb_phase_fsm, urb_bar_out
`default_nettype none

// Each input transaction is one 1 us tick carrying the sampled echo level, and each
// one yields exactly one output transaction with the trigger pin level for that tick,
// the current bar and distance latches, and a flag on the tick a new distance was
// measured. The block takes one tick per clock cycle, sustained, as long as the
// receiver keeps m_tready high, and each accepted tick is registered stage by stage:
// the first stage runs the phase sequencer and the 16x16 echo-count times scale
// multiply, the second clips the distance to 255 cm and compares it against the four
// thresholds. That multiply and the threshold compare chain set the clock period.
// There is no echo timeout; with no echo the sequencer waits in the wait phase for
// ever. Registers must be written over apb only while the stream is idle, by the
// user; the block itself does not enforce this.

module ultrasonic_range_bar_controller (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input stream, s_tdata: echo [0], zero fill above
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [urb_pkg::IN_TDATA_BITS-1:0]     s_tdata,
    // result stream, m_tdata: trigger [0], bar [4:1], distance_cm [12:5], zeros above
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [urb_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
    // m_tuser: distance_valid [0]
    output logic                                       m_tuser,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [urb_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [urb_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic      [urb_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                       pready
);
    import urb_pkg::*;

    cfg_t                 cfg;
    stage_t               st;
    logic                 st_valid;
    logic                 out_take;
    logic                 m_trigger;
    logic [BAR_BITS-1:0]  m_bar;
    logic [DIST_BITS-1:0] m_distance;
    logic                 m_dist_valid;

    // settings registers
    urb_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // phase sequencer and echo product register
    urb_phase_fsm u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .echo     (s_tdata[0]),
        .out_take (out_take),
        .st_valid (st_valid),
        .st       (st)
    );

    // distance clip, bar code and result register
    urb_bar_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .st_valid     (st_valid),
        .st           (st),
        .out_take     (out_take),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_trigger    (m_trigger),
        .m_bar        (m_bar),
        .m_distance   (m_distance),
        .m_dist_valid (m_dist_valid)
    );

    // pack the result fields, lowest field first
    assign m_tdata = {3'b000, m_distance, m_bar, m_trigger};
    assign m_tuser = m_dist_valid;

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for the ultrasonic range bar controller
// drives echo ticks and apb register writes, predicts every result transaction
// depends on urb_pkg and ultrasonic_range_bar_controller
`timescale 1ns / 1ps

module tb;
    import urb_pkg::*;

    // no stream transaction for this many cycles means the block is stuck
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_TICKS_PER_PHASE = 220;
    localparam int TICKS_PER_SETTING = 110;
    // address one past the register list, writes there must change nothing
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // one predicted result transaction
    typedef struct packed {
        logic                 trigger;
        logic [BAR_BITS-1:0]  bar;
        logic [DIST_BITS-1:0] distance;
        logic                 dist_valid;
    } range_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // predictor state, mirrors the block's registers and sequencer
    cfg_t                        cfg;
    phase_t                      ph;
    logic [PAUSE_COUNT_BITS-1:0] ph_cnt;
    logic [ECHO_COUNT_BITS-1:0]  echo_cnt;
    logic [BAR_BITS-1:0]         bar_q;
    logic [DIST_BITS-1:0]        dist_q;

    range_result_t expected_ticks[$];
    int ticks_sent = 0;
    int error_count = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    ultrasonic_range_bar_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver side backpressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // compare every accepted result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        range_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ticks.size() == 0) begin
                $error("result transaction with no tick pending, m_tdata %h", m_tdata);
                error_count++;
            end else begin
                want = expected_ticks.pop_front();
                // m_tdata: trigger [0], bar [4:1], distance_cm [12:5]
                if (m_tdata[0] !== want.trigger) begin
                    $error("trigger: expected %0d, got %0d", want.trigger, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[4:1] !== want.bar) begin
                    $error("bar: expected %b, got %b", want.bar, m_tdata[4:1]);
                    error_count++;
                end
                if (m_tdata[12:5] !== want.distance) begin
                    $error("distance_cm: expected %0d, got %0d", want.distance, m_tdata[12:5]);
                    error_count++;
                end
                if (m_tuser !== want.dist_valid) begin
                    $error("distance_valid: expected %0d, got %0d", want.dist_valid, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // watchdog on stream progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // advance the predicted sequencer by one accepted tick
    task automatic predict_tick(input logic echo);
        range_result_t res;
        logic [31:0] product;
        logic [15:0] whole_cm;
        res = '0;
        // pause ends on the tick after pause_ticks further ticks
        if (ph == PH_PAUSE) begin
            if (ph_cnt >= cfg.pause_ticks) begin
                ph = PH_TRIGGER;
                ph_cnt = '0;
                echo_cnt = '0;
            end else begin
                ph_cnt = ph_cnt + 1'b1;
            end
        end
        case (ph)
            PH_TRIGGER: begin
                // a zero trigger length still drives one tick
                res.trigger = 1'b1;
                ph_cnt = ph_cnt + 1'b1;
                if (ph_cnt >= {10'd0, cfg.trigger_ticks}) begin
                    ph = PH_WAIT;
                    ph_cnt = '0;
                    echo_cnt = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    echo_cnt = 16'd1;
                    ph = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (echo) begin
                    // wraps at the counter width
                    echo_cnt = echo_cnt + 1'b1;
                end else begin
                    product = echo_cnt * cfg.scale_q16;
                    whole_cm = product[31:16];
                    dist_q = (whole_cm > 16'd255) ? 8'd255 : whole_cm[7:0];
                    // thresholds in order, first hit wins even if unordered
                    if (dist_q <= cfg.level_one_cm)
                        bar_q = BAR_ONE;
                    else if (dist_q <= cfg.level_two_cm)
                        bar_q = BAR_TWO;
                    else if (dist_q <= cfg.level_three_cm)
                        bar_q = BAR_THREE;
                    else if (dist_q <= cfg.level_four_cm)
                        bar_q = BAR_FOUR;
                    else
                        bar_q = BAR_OFF;
                    res.dist_valid = 1'b1;
                    ph = PH_PAUSE;
                    ph_cnt = '0;
                end
            end
            default: ;
        endcase
        res.bar = bar_q;
        res.distance = dist_q;
        expected_ticks.push_back(res);
    endtask

    // send one echo tick, with random sender gaps, and predict it on acceptance
    task automatic send_tick(input logic echo);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_BITS-1){1'b0}}, echo};
        do @(posedge aclk); while (!s_tready);
        predict_tick(echo);
        ticks_sent++;
    endtask

    // stop the stream and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one apb transfer: setup cycle, then access cycle until pready
    task automatic apb_xfer(input logic wr, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_TRIGGER_TICKS: return {22'd0, cfg.trigger_ticks};
            REG_PAUSE_TICKS:   return {12'd0, cfg.pause_ticks};
            REG_SCALE_Q16:     return {16'd0, cfg.scale_q16};
            REG_LEVEL_ONE:     return {24'd0, cfg.level_one_cm};
            REG_LEVEL_TWO:     return {24'd0, cfg.level_two_cm};
            REG_LEVEL_THREE:   return {24'd0, cfg.level_three_cm};
            REG_LEVEL_FOUR:    return {24'd0, cfg.level_four_cm};
            default:           return '0;
        endcase
    endfunction

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        apb_xfer(1'b0, idx, 32'd0, rd);
        if (rd !== reg_value(idx)) begin
            $error("register %0d readback: expected %h, got %h", idx, reg_value(idx), rd);
            error_count++;
        end
    endtask

    // write a register (masked to its width), mirror it and read it back
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        case (idx)
            REG_TRIGGER_TICKS: cfg.trigger_ticks = value[9:0];
            REG_PAUSE_TICKS:   cfg.pause_ticks = value[19:0];
            REG_SCALE_Q16:     cfg.scale_q16 = value[15:0];
            REG_LEVEL_ONE:     cfg.level_one_cm = value[7:0];
            REG_LEVEL_TWO:     cfg.level_two_cm = value[7:0];
            REG_LEVEL_THREE:   cfg.level_three_cm = value[7:0];
            REG_LEVEL_FOUR:    cfg.level_four_cm = value[7:0];
            default: ;
        endcase
        if (idx != REG_UNUSED)
            check_reg(idx);
    endtask

    task automatic set_levels(input int one, input int two, input int three, input int four);
        set_reg(REG_LEVEL_ONE, one);
        set_reg(REG_LEVEL_TWO, two);
        set_reg(REG_LEVEL_THREE, three);
        set_reg(REG_LEVEL_FOUR, four);
    endtask

    // one well-formed measurement: ride out trigger and pause with noise on
    // echo, then low ticks, a high pulse and the falling tick
    task automatic measure_pulse(input int low_ticks, input int high_ticks);
        while (ph == PH_TRIGGER || ph == PH_PAUSE)
            send_tick($urandom_range(0, 1));
        repeat (low_ticks) send_tick(1'b0);
        repeat (high_ticks) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // reset values read back, then one measurement with the reset setup
    task automatic test_reset_state();
        for (int i = 0; i < 7; i++)
            check_reg(3'(i));
        measure_pulse(2, 20);
        // the reset pause is far too long to sit out
        drain_results();
        set_reg(REG_PAUSE_TICKS, 3);
    endtask

    // with full scale the distance is pulse length minus one, so pulses land
    // right on and just past each threshold
    task automatic test_bar_levels();
        set_reg(REG_SCALE_Q16, 32'hFFFF);
        set_reg(REG_TRIGGER_TICKS, 2);
        set_reg(REG_PAUSE_TICKS, 1);
        set_levels(10, 20, 30, 40);
        measure_pulse(1, 1);
        measure_pulse(0, 11);
        measure_pulse(1, 12);
        measure_pulse(0, 21);
        measure_pulse(2, 31);
        measure_pulse(0, 41);
        measure_pulse(1, 42);
        // saturates at 255, which still sits on the top threshold
        drain_results();
        set_reg(REG_LEVEL_FOUR, 255);
        measure_pulse(0, 258);
        // unordered thresholds, first match in order wins
        drain_results();
        set_levels(3, 2, 200, 100);
        measure_pulse(0, 3);
        measure_pulse(1, 5);
        measure_pulse(0, 120);
        drain_results();
        set_levels(0, 0, 0, 0);
        measure_pulse(0, 1);
        measure_pulse(0, 2);
        drain_results();
        set_levels(255, 255, 255, 255);
        measure_pulse(0, 9);
    endtask

    // trigger and pause extremes
    task automatic test_phase_lengths();
        drain_results();
        set_levels(5, 10, 15, 20);
        set_reg(REG_PAUSE_TICKS, 0);
        set_reg(REG_TRIGGER_TICKS, 0);
        measure_pulse(0, 3);
        measure_pulse(1, 2);
        drain_results();
        set_reg(REG_TRIGGER_TICKS, 64);
        measure_pulse(0, 5);
        // upper bits beyond the field are dropped
        drain_results();
        set_reg(REG_TRIGGER_TICKS, 32'hFFFF_FC05);
        measure_pulse(3, 4);
        measure_pulse(1, 6);
        // longest pause: sit in it for a while, then shorten it
        drain_results();
        set_reg(REG_PAUSE_TICKS, 32'h000F_FFFF);
        repeat (60) send_tick($urandom_range(0, 1));
        drain_results();
        set_reg(REG_PAUSE_TICKS, 0);
        measure_pulse(0, 8);
    endtask

    task automatic test_scale_extremes();
        drain_results();
        set_reg(REG_SCALE_Q16, 0);
        measure_pulse(0, 40);
        drain_results();
        set_reg(REG_SCALE_Q16, 1);
        measure_pulse(1, 20);
        drain_results();
        set_reg(REG_SCALE_Q16, 32'hFFFF);
        measure_pulse(0, 17);
    endtask

    // a write past the register list leaves every register alone
    task automatic test_unused_address();
        drain_results();
        set_reg(REG_UNUSED, 32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++)
            check_reg(3'(i));
        measure_pulse(0, 10);
    endtask

    task automatic randomize_setup();
        int l1;
        int l2;
        int l3;
        set_reg(REG_TRIGGER_TICKS, $urandom_range(0, 12));
        set_reg(REG_PAUSE_TICKS, $urandom_range(0, 20));
        case ($urandom_range(0, 3))
            0:       set_reg(REG_SCALE_Q16, 32'hFFFF);
            1:       set_reg(REG_SCALE_Q16, $urandom_range(0, 65535));
            default: set_reg(REG_SCALE_Q16, $urandom_range(8000, 65535));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            set_levels($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
            l1 = $urandom_range(0, 15);
            l2 = l1 + $urandom_range(0, 15);
            l3 = l2 + $urandom_range(0, 15);
            set_levels(l1, l2, l3, l3 + $urandom_range(0, 15));
        end
    endtask

    function automatic int pick_pulse();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 1;
        if (r < 20)
            return $urandom_range(200, 400);
        return $urandom_range(1, 64);
    endfunction

    // random measurements under each idling pattern, new setup every so often
    task automatic test_random_ticks();
        int phase_end;
        int setting_end;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin src_idle_pct = 36; sink_stall_pct = 70; end
                1: begin src_idle_pct = 70; sink_stall_pct = 36; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            phase_end = ticks_sent + RANDOM_TICKS_PER_PHASE;
            while (ticks_sent < phase_end) begin
                drain_results();
                randomize_setup();
                setting_end = ticks_sent + TICKS_PER_SETTING;
                while (ticks_sent < setting_end && ticks_sent < phase_end)
                    measure_pulse($urandom_range(0, 6), pick_pulse());
            end
        end
    endtask

    initial begin
        // predictor starts from the block's reset state
        cfg.trigger_ticks = 10'd10;
        cfg.pause_ticks = 20'd100000;
        cfg.scale_q16 = 16'd1114;
        cfg.level_one_cm = 8'd5;
        cfg.level_two_cm = 8'd10;
        cfg.level_three_cm = 8'd15;
        cfg.level_four_cm = 8'd20;
        ph = PH_TRIGGER;
        ph_cnt = '0;
        echo_cnt = '0;
        bar_q = BAR_OFF;
        dist_q = '0;
        src_idle_pct = 36;
        sink_stall_pct = 70;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_bar_levels();
        test_phase_lengths();
        test_scale_extremes();
        test_unused_address();
        test_random_ticks();

        drain_results();
        repeat (6) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/urb_pkg.sv
sv/urb_cfg_regs.sv
sv/urb_phase_fsm.sv
sv/urb_bar_out.sv
sv/ultrasonic_range_bar_controller.sv
tb/tb.sv
